>>> rtl/sound_light_lamp_controller_core_macros.svh
// ---------------------------------------------------------------------------
// sound light lamp controller assertion macros
// shared property forms for the controller rtl, clocked on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef SOUND_LIGHT_LAMP_CONTROLLER_CORE_MACROS_SVH
`define SOUND_LIGHT_LAMP_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define SLC_ASSERT_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define SLC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/slc_pkg.sv
// ---------------------------------------------------------------------------
// slc_pkg
// types, sizes and constants shared by the lamp controller rtl
// ---------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

	localparam int RING_DEPTH  = 500;
	localparam int SAMPLE_BITS = 12;
	localparam int POS_BITS    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_BITS    = SAMPLE_BITS + POS_BITS;

	// mean = floor(sum / RING_DEPTH) as (sum * DIV_MULT) >> DIV_SHIFT
	localparam int DIV_SHIFT = SUM_BITS + POS_BITS;
	localparam logic [63:0] DIV_MULT =
		((64'd1 << DIV_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
	localparam int MULT_BITS = DIV_SHIFT - POS_BITS + 1;
	localparam int PROD_BITS = SUM_BITS + MULT_BITS;

	// threshold is 11/10 of the mean
	localparam int THR_NUM  = 11;
	localparam int THR_DEN  = 10;
	localparam int CMP_BITS = SAMPLE_BITS + 5;

	localparam int AUDIO_BITS     = 12;
	localparam int LUX_BITS       = 17;
	localparam int HOLD_BITS      = 16;
	localparam int CFG_DATA_BITS  = 17;
	localparam int CFG_INDEX_BITS = 2;
	localparam int LEVEL_BITS     = (SAMPLE_BITS > AUDIO_BITS) ? SAMPLE_BITS : AUDIO_BITS;

	localparam logic [SAMPLE_BITS-1:0] INIT_LEVEL       = SAMPLE_BITS'(32'h9C4);
	localparam logic [AUDIO_BITS-1:0]  AUDIO_MIN_RESET  = AUDIO_BITS'(2500);
	localparam logic [LUX_BITS-1:0]    LUX_MIN_RESET    = '0;
	localparam logic [HOLD_BITS-1:0]   HOLD_TICKS_RESET = HOLD_BITS'(1000);

	typedef enum logic [1:0] {
		REQ_AUDIO  = 2'd0,
		REQ_BUTTON = 2'd1,
		REQ_TICK   = 2'd2
	} req_kind_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_AUDIO_MIN  = 2'd0,
		CFG_LUX_MIN    = 2'd1,
		CFG_HOLD_TICKS = 2'd2
	} cfg_reg_t;

	// decoded event; audio, button and tick are low when nothing is processed
	typedef struct packed {
		logic audio;
		logic button;
		logic tick;
		logic trig;
		logic released;
	} evt_t;

	typedef struct packed {
		logic lamp_lit;
		logic indicator_flip;
		logic debounce_active;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/slc_req_if.sv
// ---------------------------------------------------------------------------
// slc_req_if
// event channel into the lamp controller, valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface slc_req_if;
	import slc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [1:0]             req_type;
	logic [SAMPLE_BITS-1:0] sample;
	logic [LUX_BITS-1:0]    lux;
	logic                   button_released;

	modport source (
		output valid, req_type, sample, lux, button_released,
		input  ready
	);

	modport sink (
		input  valid, req_type, sample, lux, button_released,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/slc_rsp_if.sv
// ---------------------------------------------------------------------------
// slc_rsp_if
// result channel out of the lamp controller, valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface slc_rsp_if;
	logic valid;
	logic ready;
	logic lamp_lit;
	logic indicator_flip;
	logic debounce_active;

	modport source (
		output valid, lamp_lit, indicator_flip, debounce_active,
		input  ready
	);

	modport sink (
		input  valid, lamp_lit, indicator_flip, debounce_active,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/sound_light_lamp_controller_core.sv
// ---------------------------------------------------------------------------
// sound_light_lamp_controller_core
// lamp controller driven by audio samples, button edges and timer ticks
//
// req carries one event per transaction: req_type selects an audio sample
// (sample and lux used), a button falling edge, or a debounce timer tick
// (button_released used). rsp returns exactly one transaction per event with
// the lamp state, the indicator toggle and the timer state after the event.
// cfg_wr_en/cfg_index/cfg_data write one of audio_level_min, lux_level_min
// or hold_ticks per write; write them only while no event is in flight.
// rsp valid is registered: input register, then output register. one event
// per cycle is sustained while rsp is ready, bounded by the running sum add
// and the reciprocal multiply that forms the ring mean in the event stage.
// the 500-entry sample ring is not cleared: a position counter and a
// wrapped flag stand in for its reset contents, so events are taken from
// the first cycle after reset. reset sets lamp off, button disarmed, timer
// stopped and registers to their defaults.
// when rsp stalls, the result holds in the output register, one more event
// waits in the input register, and req ready then drops.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sound_light_lamp_controller_core_macros.svh"

module sound_light_lamp_controller_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	slc_req_if.sink                                 req,
	slc_rsp_if.source                               rsp,
	input  wire logic                               cfg_wr_en,
	input  wire logic [slc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [slc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import slc_pkg::*;

	logic [AUDIO_BITS-1:0]  audio_min_q;
	logic [LUX_BITS-1:0]    lux_min_q;
	logic [HOLD_BITS-1:0]   hold_ticks_q;

	logic                   valid_s1;
	logic [1:0]             req_type_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [LUX_BITS-1:0]    lux_s1;
	logic                   released_s1;

	logic                   rsp_valid_q;
	res_t                   res_q;

	logic                   advance;
	logic                   fire;
	logic                   above_mean;
	logic                   loud;
	evt_t                   evt;
	res_t                   res;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	assign loud = above_mean && (LEVEL_BITS'(sample_s1) >= LEVEL_BITS'(audio_min_q));

	always_comb begin
		evt.audio    = fire && (req_type_s1 == REQ_AUDIO);
		evt.button   = fire && (req_type_s1 == REQ_BUTTON);
		evt.tick     = fire && (req_type_s1 == REQ_TICK);
		evt.trig     = loud || (lux_s1 < lux_min_q);
		evt.released = released_s1;
	end

	slc_ring u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (evt.audio),
		.sample     (sample_s1),
		.above_mean (above_mean)
	);

	slc_lamp u_lamp (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt),
		.hold_ticks (hold_ticks_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_min_q  <= AUDIO_MIN_RESET;
			lux_min_q    <= LUX_MIN_RESET;
			hold_ticks_q <= HOLD_TICKS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_AUDIO_MIN:  audio_min_q  <= cfg_data[AUDIO_BITS-1:0];
				CFG_LUX_MIN:    lux_min_q    <= cfg_data[LUX_BITS-1:0];
				CFG_HOLD_TICKS: hold_ticks_q <= cfg_data[HOLD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1 <= req.req_type;
			sample_s1   <= req.sample;
			lux_s1      <= req.lux;
			released_s1 <= req.button_released;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.lamp_lit        = res_q.lamp_lit;
	assign rsp.indicator_flip  = res_q.indicator_flip;
	assign rsp.debounce_active = res_q.debounce_active;

	`SLC_ASSERT_NEXT(a_fire_gives_result, fire, rsp_valid_q, "processed event left no result")
	`SLC_ASSERT_NEXT(a_flip_audio_only, fire && (req_type_s1 != REQ_AUDIO), !res_q.indicator_flip, "indicator flip on non-audio event")

endmodule

`default_nettype wire

>>> rtl/slc_ring.sv
// ---------------------------------------------------------------------------
// slc_ring
// sample ring with running sum, mean and 1.1x mean threshold compare
// ---------------------------------------------------------------------------
`default_nettype none

`include "sound_light_lamp_controller_core_macros.svh"

module slc_ring (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire logic [slc_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                above_mean
);
	import slc_pkg::*;

	localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(RING_DEPTH - 1);

	logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [POS_BITS-1:0]    ring_pos_q;
	logic [SUM_BITS-1:0]    ring_sum_q;
	logic                   wrapped_q;

	logic [POS_BITS-1:0]    pos_next;
	logic [POS_BITS-1:0]    rd_addr;
	logic [SAMPLE_BITS-1:0] oldest;
	logic [SUM_BITS-1:0]    sum_next;
	logic [PROD_BITS-1:0]   prod;
	logic [SAMPLE_BITS-1:0] mean;
	logic [CMP_BITS-1:0]    thr_lhs;
	logic [CMP_BITS-1:0]    thr_rhs;

	assign pos_next = (ring_pos_q == POS_LAST) ? '0 : ring_pos_q + POS_BITS'(1);

	// rd_q always holds the entry at ring_pos_q: fetch ahead when the position moves
	assign rd_addr = push ? pos_next : ring_pos_q;

	// first pass reads the reset contents, not the memory
	always_comb begin
		if (wrapped_q) begin
			oldest = rd_q;
		end else if (ring_pos_q == '0) begin
			oldest = INIT_LEVEL;
		end else begin
			oldest = '0;
		end
	end

	assign sum_next = ring_sum_q - SUM_BITS'(oldest) + SUM_BITS'(sample);

	// reciprocal multiply for the mean
	assign prod = PROD_BITS'(ring_sum_q) * PROD_BITS'(DIV_MULT);
	assign mean = prod[DIV_SHIFT +: SAMPLE_BITS];

	// sample >= floor(mean * 11 / 10)  <=>  11 * mean < 10 * (sample + 1)
	assign thr_lhs    = CMP_BITS'(THR_NUM) * CMP_BITS'(mean);
	assign thr_rhs    = CMP_BITS'(THR_DEN) * (CMP_BITS'(sample) + CMP_BITS'(1));
	assign above_mean = thr_lhs < thr_rhs;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[ring_pos_q] <= sample;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_pos_q <= '0;
			ring_sum_q <= SUM_BITS'(INIT_LEVEL);
			wrapped_q  <= 1'b0;
		end else if (push) begin
			ring_pos_q <= pos_next;
			ring_sum_q <= sum_next;
			if (ring_pos_q == POS_LAST) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	`SLC_ASSERT_NEXT(a_ring_wrap, push && (ring_pos_q == POS_LAST), (ring_pos_q == '0) && wrapped_q, "ring position did not wrap")

endmodule

`default_nettype wire

>>> rtl/slc_lamp.sv
// ---------------------------------------------------------------------------
// slc_lamp
// lamp, button arm, debounce timer and hold count state
// ---------------------------------------------------------------------------
`default_nettype none

`include "sound_light_lamp_controller_core_macros.svh"

module slc_lamp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire slc_pkg::evt_t                evt,
	input  wire logic [slc_pkg::HOLD_BITS-1:0] hold_ticks,
	output slc_pkg::res_t                     res
);
	import slc_pkg::*;

	logic                 lamp_q;
	logic                 armed_q;
	logic                 timer_q;
	logic [HOLD_BITS-1:0] hold_q;

	logic                 lamp_d;
	logic                 armed_d;
	logic                 timer_d;
	logic [HOLD_BITS-1:0] hold_d;
	logic                 flip;

	always_comb begin
		lamp_d  = lamp_q;
		armed_d = armed_q;
		timer_d = timer_q;
		hold_d  = hold_q;
		flip    = 1'b0;
		if (evt.audio) begin
			if (evt.trig) begin
				flip = 1'b1;
				// already on: restart the hold period
				if (lamp_q) begin
					hold_d = '0;
				end else begin
					lamp_d = 1'b1;
				end
			end
		end else if (evt.button) begin
			if (armed_q) begin
				armed_d = 1'b0;
				lamp_d  = !lamp_q;
			end
			timer_d = 1'b1;
		end else if (evt.tick && timer_q && evt.released) begin
			armed_d = 1'b1;
			if (lamp_q) begin
				if (hold_q == hold_ticks) begin
					hold_d  = '0;
					lamp_d  = 1'b0;
					timer_d = 1'b0;
				end else begin
					hold_d = hold_q + HOLD_BITS'(1);
				end
			end else begin
				timer_d = 1'b0;
			end
		end
		res.lamp_lit        = lamp_d;
		res.indicator_flip  = flip;
		res.debounce_active = timer_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q  <= 1'b0;
			armed_q <= 1'b0;
			timer_q <= 1'b0;
			hold_q  <= '0;
		end else begin
			lamp_q  <= lamp_d;
			armed_q <= armed_d;
			timer_q <= timer_d;
			hold_q  <= hold_d;
		end
	end

	`SLC_ASSERT_NEXT(a_button_starts_timer, evt.button, timer_q, "button edge did not start timer")
	`SLC_ASSERT_NEXT(a_release_arms, evt.tick && timer_q && evt.released, armed_q, "released tick did not arm button")

endmodule

`default_nettype wire

>>> tb/tb_sound_light_lamp_controller_core.sv
// ---------------------------------------------------------------------------
// tb_sound_light_lamp_controller_core
// self-checking bench for the lamp controller: a table of directed events
// after reset, then random events under several register settings and a
// run of timer ticks up to a hold expiry at a large hold count; every
// result is compared with the table's expected value or with an in-bench
// model of the lamp, timer and ring
module tb_sound_light_lamp_controller_core;
	import slc_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
	localparam int LUX_MAX     = 83866;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 300;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [1:0]             kind;
		logic [SAMPLE_BITS-1:0] smp;
		logic [LUX_BITS-1:0]    lx;
		logic                   rel;
		logic                   typed;
		res_t                   want;   // lamp, flip, timer
	} dir_row_t;

	localparam int DIR_COUNT = 20;
	localparam dir_row_t DIRECTED_ROWS [DIR_COUNT] = '{
		'{REQ_TICK,   12'd0,    17'd0,     1'b1, 1'b1, 3'b000}, // tick, timer stopped
		'{REQ_UNUSED, 12'd4095, 17'd83866, 1'b1, 1'b1, 3'b000}, // unused kind
		'{REQ_BUTTON, 12'd0,    17'd0,     1'b0, 1'b1, 3'b001}, // edge while disarmed
		'{REQ_TICK,   12'd0,    17'd0,     1'b0, 1'b1, 3'b001}, // button held
		'{REQ_TICK,   12'd0,    17'd0,     1'b1, 1'b1, 3'b000}, // released, lamp off
		'{REQ_BUTTON, 12'd0,    17'd0,     1'b0, 1'b1, 3'b101}, // armed edge, lamp on
		'{REQ_AUDIO,  12'd0,    17'd0,     1'b0, 1'b1, 3'b101}, // below threshold
		'{REQ_AUDIO,  12'd4095, 17'd83866, 1'b0, 1'b1, 3'b111}, // trigger, lamp on
		'{REQ_AUDIO,  12'd2499, 17'd0,     1'b0, 1'b1, 3'b101}, // just below level
		'{REQ_AUDIO,  12'd2500, 17'd0,     1'b0, 1'b0, 3'b000},
		'{REQ_TICK,   12'd0,    17'd0,     1'b1, 1'b0, 3'b000},
		'{REQ_TICK,   12'd0,    17'd0,     1'b1, 1'b0, 3'b000},
		'{REQ_BUTTON, 12'd0,    17'd0,     1'b0, 1'b0, 3'b000},
		'{REQ_AUDIO,  12'd4095, 17'd0,     1'b0, 1'b0, 3'b000},
		'{REQ_AUDIO,  12'd100,  17'd83866, 1'b0, 1'b0, 3'b000},
		'{REQ_UNUSED, 12'd0,    17'd0,     1'b0, 1'b0, 3'b000},
		'{REQ_TICK,   12'd0,    17'd0,     1'b0, 1'b0, 3'b000},
		'{REQ_BUTTON, 12'd0,    17'd0,     1'b0, 1'b0, 3'b000},
		'{REQ_TICK,   12'd0,    17'd0,     1'b1, 1'b0, 3'b000},
		'{REQ_AUDIO,  12'd2048, 17'h0FFFF, 1'b0, 1'b0, 3'b000}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic                      cfg_wr_en;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	slc_req_if req_ch ();
	slc_rsp_if rsp_ch ();

	sound_light_lamp_controller_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state
	logic                   lamp_is_on;
	logic                   btn_armed;
	logic                   tmr_running;
	logic [HOLD_BITS-1:0]   hold_cnt;
	logic [SAMPLE_BITS-1:0] lvl_ring [RING_DEPTH];
	int                     ring_wr;
	int unsigned            lvl_sum;
	logic [AUDIO_BITS-1:0]  cfg_audio_min;
	logic [LUX_BITS-1:0]    cfg_lux_min;
	logic [HOLD_BITS-1:0]   cfg_hold_ticks;

	res_t pending_lamp_states [$];
	int   mismatch_count = 0;
	int   burst_left = 0;

	function automatic int unsigned mean_threshold();
		return ((lvl_sum / RING_DEPTH) * THR_NUM) / THR_DEN;
	endfunction

	function automatic res_t advance_lamp_state(input logic [1:0] kind,
			input logic [SAMPLE_BITS-1:0] smp, input logic [LUX_BITS-1:0] lx,
			input logic rel);
		int unsigned thr;
		logic        flip;
		res_t        r;
		flip = 1'b0;
		case (kind)
			REQ_AUDIO: begin
				// threshold comes from the ring before the new sample goes in
				thr = mean_threshold();
				lvl_sum = lvl_sum - lvl_ring[ring_wr] + smp;
				lvl_ring[ring_wr] = smp;
				ring_wr = (ring_wr == RING_DEPTH - 1) ? 0 : ring_wr + 1;
				if ((smp >= thr && smp >= cfg_audio_min) || lx < cfg_lux_min) begin
					flip = 1'b1;
					if (lamp_is_on)
						hold_cnt = '0;
					else
						lamp_is_on = 1'b1;
				end
			end
			REQ_BUTTON: begin
				if (btn_armed) begin
					btn_armed  = 1'b0;
					lamp_is_on = !lamp_is_on;
				end
				tmr_running = 1'b1;
			end
			REQ_TICK: begin
				if (tmr_running && rel) begin
					btn_armed = 1'b1;
					if (!lamp_is_on) begin
						tmr_running = 1'b0;
					end else if (hold_cnt == cfg_hold_ticks) begin
						hold_cnt    = '0;
						lamp_is_on  = 1'b0;
						tmr_running = 1'b0;
					end else begin
						hold_cnt = hold_cnt + 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.lamp_lit        = lamp_is_on;
		r.indicator_flip  = flip;
		r.debounce_active = tmr_running;
		return r;
	endfunction

	task automatic send_event(input logic [1:0] kind, input logic [SAMPLE_BITS-1:0] smp,
			input logic [LUX_BITS-1:0] lx, input logic rel, input logic typed,
			input res_t typed_want);
		int   gap_len;
		res_t pred;
		if (burst_left == 0) begin
			gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap_len > 0) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
				repeat (gap_len - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		@(negedge clk);
		req_ch.valid           <= 1'b1;
		req_ch.req_type        <= kind;
		req_ch.sample          <= smp;
		req_ch.lux             <= lx;
		req_ch.button_released <= rel;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
		pred = advance_lamp_state(kind, smp, lx, rel);
		pending_lamp_states.push_back(typed ? typed_want : pred);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_lamp_states.size() != 0) @(posedge clk);
	endtask

	task automatic write_settings(input logic [AUDIO_BITS-1:0] audio_min,
			input logic [LUX_BITS-1:0] lux_min, input logic [HOLD_BITS-1:0] hold);
		wait_drained();
		// idle cycles after the last result, before the writes
		repeat (3) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_AUDIO_MIN;
		cfg_data  <= CFG_DATA_BITS'(audio_min);
		@(negedge clk);
		cfg_index <= CFG_LUX_MIN;
		cfg_data  <= CFG_DATA_BITS'(lux_min);
		@(negedge clk);
		cfg_index <= CFG_HOLD_TICKS;
		cfg_data  <= CFG_DATA_BITS'(hold);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_audio_min  = audio_min;
		cfg_lux_min    = lux_min;
		cfg_hold_ticks = hold;
	endtask

	task automatic check_field(input string fname, input logic want, input logic got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t %s mismatch: expected %0b actual %0b", $time, fname, want, got);
		end
	endtask

	// result side stalls on a random 16-bit ready pattern, drawn anew once all its bits are spent
	logic [15:0] ready_pat;
	int          pat_bit = 0;
	always @(negedge clk) begin
		if (pat_bit == 0) begin
			case ($urandom_range(0, 7))
				0, 1, 2: ready_pat = 16'hFFFF;
				3:       ready_pat = 16'h0000;
				default: ready_pat = 16'($urandom);
			endcase
			pat_bit = 16;
		end
		pat_bit = pat_bit - 1;
		rsp_ch.ready <= ready_pat[pat_bit];
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_lamp_states.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t unexpected result: lamp %0b flip %0b timer %0b", $time,
						rsp_ch.lamp_lit, rsp_ch.indicator_flip, rsp_ch.debounce_active);
			end else begin
				want = pending_lamp_states.pop_front();
				check_field("lamp_lit", want.lamp_lit, rsp_ch.lamp_lit);
				check_field("indicator_flip", want.indicator_flip, rsp_ch.indicator_flip);
				check_field("debounce_active", want.debounce_active, rsp_ch.debounce_active);
			end
		end
	end

	initial begin : stimulus
		dir_row_t               row;
		logic [1:0]             kind;
		logic [SAMPLE_BITS-1:0] smp;
		logic [LUX_BITS-1:0]    lx;
		logic                   rel;
		logic [AUDIO_BITS-1:0]  set_audio;
		logic [LUX_BITS-1:0]    set_lux;
		logic [HOLD_BITS-1:0]   set_hold;
		int                     pick;
		int                     near;
		int                     guard;

		arst_n                 = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.req_type        = REQ_AUDIO;
		req_ch.sample          = '0;
		req_ch.lux             = '0;
		req_ch.button_released = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_index              = CFG_AUDIO_MIN;
		cfg_data               = '0;

		lamp_is_on     = 1'b0;
		btn_armed      = 1'b0;
		tmr_running    = 1'b0;
		hold_cnt       = '0;
		for (int n = 0; n < RING_DEPTH; n++)
			lvl_ring[n] = '0;
		lvl_ring[0]    = INIT_LEVEL;
		ring_wr        = 0;
		lvl_sum        = INIT_LEVEL;
		cfg_audio_min  = AUDIO_MIN_RESET;
		cfg_lux_min    = LUX_MIN_RESET;
		cfg_hold_ticks = HOLD_TICKS_RESET;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int n = 0; n < DIR_COUNT; n++) begin
			row = DIRECTED_ROWS[n];
			send_event(row.kind, row.smp, row.lx, row.rel, row.typed, row.want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					set_audio = '0;
					set_lux   = LUX_BITS'(LUX_MAX);
					set_hold  = '0;
				end
				1: begin
					set_audio = AUDIO_BITS'(SAMPLE_MAX);
					set_lux   = '0;
					set_hold  = '1;
				end
				2: begin
					set_audio = AUDIO_BITS'($urandom_range(0, SAMPLE_MAX));
					set_lux   = LUX_BITS'($urandom_range(0, LUX_MAX));
					set_hold  = HOLD_BITS'($urandom_range(0, 8));
				end
				3: begin
					set_audio = AUDIO_BITS'($urandom_range(1500, 3000));
					set_lux   = LUX_BITS'($urandom_range(0, LUX_MAX));
					set_hold  = HOLD_BITS'($urandom_range(0, 30));
				end
				4: begin
					set_audio = AUDIO_BITS'($urandom_range(0, SAMPLE_MAX));
					set_lux   = '0;
					set_hold  = HOLD_BITS'($urandom_range(1, 4));
				end
				default: begin
					set_audio = AUDIO_MIN_RESET;
					set_lux   = LUX_MIN_RESET;
					set_hold  = HOLD_TICKS_RESET;
				end
			endcase
			write_settings(set_audio, set_lux, set_hold);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				smp  = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
				lx   = LUX_BITS'($urandom_range(0, LUX_MAX));
				rel  = ($urandom_range(0, 4) != 0);
				if (pick < 50) begin
					kind = REQ_AUDIO;
					case ($urandom_range(0, 3))
						// aim at the ring threshold or the absolute level, else an extreme or the raw sample
						0: near = int'(mean_threshold()) + int'($urandom_range(0, 4)) - 2;
						1: near = int'(cfg_audio_min) + int'($urandom_range(0, 4)) - 2;
						2: near = ($urandom_range(0, 1) == 0) ? 0 : SAMPLE_MAX;
						default: near = int'(smp);
					endcase
					near = (near < 0) ? 0 : (near > SAMPLE_MAX) ? SAMPLE_MAX : near;
					smp  = SAMPLE_BITS'(near);
					if ($urandom_range(0, 3) == 0) begin
						near = int'(cfg_lux_min) + int'($urandom_range(0, 2)) - 1;
						near = (near < 0) ? 0 : (near > LUX_MAX) ? LUX_MAX : near;
						lx   = LUX_BITS'(near);
					end
				end else if (pick < 65) begin
					kind = REQ_BUTTON;
				end else if (pick < 95) begin
					kind = REQ_TICK;
				end else begin
					kind = REQ_UNUSED;
				end
				send_event(kind, smp, lx, rel, 1'b0, '0);
			end
		end

		// hold expiry at a large count: climb under the widest hold_ticks, then
		// set the limit five ticks above the current count
		write_settings(AUDIO_BITS'(SAMPLE_MAX), LUX_BITS'(LUX_MAX), '1);
		guard = 0;
		while (!(lamp_is_on && tmr_running) && guard < 20) begin
			if (!tmr_running)
				send_event(REQ_BUTTON, '0, '0, 1'b0, 1'b0, '0);
			else
				send_event(REQ_AUDIO, '0, '0, 1'b0, 1'b0, '0);
			guard++;
		end
		repeat (20) send_event(REQ_TICK, '0, '0, 1'b1, 1'b0, '0);
		write_settings(AUDIO_BITS'(SAMPLE_MAX), LUX_BITS'(LUX_MAX), hold_cnt + HOLD_BITS'(5));
		guard = 0;
		while (lamp_is_on && guard < 20) begin
			send_event(REQ_TICK, '0, '0, 1'b1, 1'b0, '0);
			guard++;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_lamp_states.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#30000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
